// File: rtl/nlta_pkg.sv
// ----------------------------------------------------------------------------
// nlta_pkg
// shared types and constants of the neighbour location table
// ----------------------------------------------------------------------------
package nlta_pkg;
   localparam int TableDepth = 32;
   localparam int IdxW = $clog2(TableDepth);
   localparam int CntW = 7;

   localparam logic [1:0] FUNC_BEACON = 2'd0;
   localparam logic [1:0] FUNC_CLEAN  = 2'd1;
   localparam logic [1:0] FUNC_FRESH  = 2'd2;
   localparam logic [1:0] FUNC_SPARE  = 2'd3;

   localparam logic [2:0] ST_ADDED    = 3'd0;
   localparam logic [2:0] ST_REPLACED = 3'd1;
   localparam logic [2:0] ST_DUP      = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_CLEAN    = 3'd4;
   localparam logic [2:0] ST_FRESH    = 3'd5;
   localparam logic [2:0] ST_NONE     = 3'd6;

   localparam logic [1:0] CSR_OWN_ID   = 2'd0;
   localparam logic [1:0] CSR_LIFETIME = 2'd1;
   localparam logic [1:0] CSR_WINDOW   = 2'd2;

   typedef enum logic [1:0] {S_IDLE, S_BEACON, S_SCAN, S_DONE} state_type;

   // entry contents held in one cell
   typedef struct packed {
      logic        valid;
      logic [31:0] id;
      logic [62:0] sender_time;
      logic [62:0] arrival_time;
      logic [31:0] latitude;
      logic [31:0] longitude;
      logic [15:0] speed;
      logic [15:0] heading;
      logic [15:0] pos_index;
   } entry_type;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic        write_hit;   // overwrite the matching cell
      logic        write_free;  // fill the first free cell
      logic        rotate;      // shift the ring by one cell
      logic        evict;       // evict the head cell if aged
      entry_type   wdata;
      logic [31:0] match_id;
      logic [62:0] now;
      logic [62:0] lifetime;
   } cell_ctrl_type;
endpackage

// File: rtl/nlta_cell.sv
// ----------------------------------------------------------------------------
// nlta_cell
// one table slot: local id match, write, and hand-over to its neighbour
// ----------------------------------------------------------------------------
module nlta_cell import nlta_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          first_hit,
   input  logic          first_free,
   input  entry_type     prev_entry,
   output entry_type     entry,
   output logic          hit,
   output logic          free
);
   entry_type entry_ff, entry_in;

   assign entry = entry_ff;
   assign hit   = entry_ff.valid && entry_ff.id == ctrl.match_id;
   assign free  = !entry_ff.valid;

   // next contents, reset only empties the slot
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.rotate) begin
         entry_in = prev_entry;
      end else if ((ctrl.write_hit && first_hit) || (ctrl.write_free && first_free)) begin
         entry_in = ctrl.wdata;
      end
      if (reset) begin
         entry_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end
endmodule

// File: rtl/nlta_chain.sv
// ----------------------------------------------------------------------------
// nlta_chain
// ring of cells with priority match and head-of-ring evict
// ----------------------------------------------------------------------------
module nlta_chain import nlta_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   output entry_type     head,
   output logic          any_hit,
   output logic          any_free,
   output logic [62:0]   hit_sender_time
);
   entry_type             ent  [TableDepth];
   entry_type             prv  [TableDepth];
   logic [TableDepth-1:0] hit, free, fh, ff;
   logic [TableDepth-1:0] hb, fb;
   entry_type             wrap;

   // the tail receives the head entry, cleared if evicted
   always_comb begin
      wrap = ent[0];
      if (ctrl.evict && ctrl.now >= ent[0].sender_time &&
          (ctrl.now - ent[0].sender_time) >= ctrl.lifetime) begin
         wrap.valid = 1'b0;
      end
   end

   // first match and first free slot
   always_comb begin
      hb[0] = 1'b0;
      fb[0] = 1'b0;
      for (int i = 1; i < TableDepth; i++) begin
         hb[i] = hb[i-1] | hit[i-1];
         fb[i] = fb[i-1] | free[i-1];
      end
      fh = hit & ~hb;
      ff = free & ~fb;
      hit_sender_time = '0;
      for (int i = 0; i < TableDepth; i++) begin
         if (fh[i]) hit_sender_time = ent[i].sender_time;
      end
   end

   genvar g;
   for (g = 0; g < TableDepth; g++) begin : g_cell
      if (g == TableDepth - 1) begin : g_tail
         assign prv[g] = wrap;
      end else begin : g_mid
         assign prv[g] = ent[g+1];
      end
      nlta_cell u_cell (
         .clock(clock), .reset(reset), .ctrl(ctrl),
         .first_hit(fh[g]), .first_free(ff[g] && !any_hit),
         .prev_entry(prv[g]), .entry(ent[g]), .hit(hit[g]), .free(free[g])
      );
   end

   assign head     = ent[0];
   assign any_hit  = |hit;
   assign any_free = |free;
endmodule

// File: rtl/neighbor_location_table_aging_unit.sv
// ----------------------------------------------------------------------------
// neighbor_location_table_aging_unit
// neighbour beacon table with id match, timestamp aging and fresh listing
// ----------------------------------------------------------------------------
// beacon: the beacon state matches in parallel over all cells and registers the result
// clean tick and fresh query: the ring rotates one cell
// per cycle past the head, which evicts or lists; at most one result per cycle
// a new transfer is taken only while idle, when the last one is through
// the receiver cannot stall; busy is high from transfer to last result
// reset empties the table and restores the register defaults
module neighbor_location_table_aging_unit import nlta_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_node_id,
   input  logic [62:0] req_sender_time_ns,
   input  logic [31:0] req_latitude,
   input  logic [31:0] req_longitude,
   input  logic [15:0] req_speed,
   input  logic [15:0] req_heading,
   input  logic [15:0] req_position_index,
   input  logic [62:0] req_now_ns,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [62:0] csr_wdata,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_neighbor_id,
   output logic [62:0] rsp_age_ns,
   output logic [6:0]  rsp_removed_count,
   output logic [6:0]  rsp_entry_count,
   output logic        rsp_last
);
   state_type     state_ff, state_in;
   logic [31:0]   own_ff;
   logic [62:0]   life_ff, win_ff;
   logic [1:0]    func_ff;
   entry_type     wd_ff;
   logic [IdxW:0] step_ff, step_in;
   logic [CntW-1:0] cnt_ff, cnt_in, rem_ff, rem_in;
   logic          found_ff, found_in;
   cell_ctrl_type ctrl;
   entry_type     head;
   logic          any_hit, any_free, head_aged, head_fresh;
   logic [62:0]   hit_ts, age;
   logic          strobe_in, last_in;
   logic [2:0]    status_in;
   logic [31:0]   nid_in;
   logic [62:0]   age_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff  <= '0;
         life_ff <= 63'd1000000000;
         win_ff  <= 63'd100000000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OWN_ID:   own_ff  <= csr_wdata[31:0];
            CSR_LIFETIME: life_ff <= csr_wdata;
            CSR_WINDOW:   win_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // captured item
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         func_ff <= req_func;
         wd_ff   <= '{1'b1, req_node_id, req_sender_time_ns, req_now_ns, req_latitude,
                      req_longitude, req_speed, req_heading, req_position_index};
      end
   end

   assign head_aged = wd_ff.arrival_time >= head.sender_time &&
                      (wd_ff.arrival_time - head.sender_time) >= life_ff;
   assign age = (wd_ff.arrival_time >= head.arrival_time) ?
                wd_ff.arrival_time - head.arrival_time : '0;
   assign head_fresh = head.valid && head.id != own_ff && age < win_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (start) begin
            if (req_func == FUNC_BEACON) state_in = S_BEACON;
            else if (req_func == FUNC_CLEAN || req_func == FUNC_FRESH) state_in = S_SCAN;
         end
         S_BEACON: state_in = S_IDLE;
         S_SCAN: if (step_ff == IdxW'(TableDepth - 1) + (IdxW+1)'(0)) state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      ctrl          = '0;
      ctrl.wdata    = wd_ff;
      ctrl.match_id = wd_ff.id;
      ctrl.now      = wd_ff.arrival_time;
      ctrl.lifetime = life_ff;
      step_in   = step_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      found_in  = found_ff;
      strobe_in = 1'b0;
      last_in   = 1'b1;
      status_in = ST_NONE;
      nid_in    = '0;
      age_in    = '0;
      case (state_ff)
         S_IDLE: begin
            step_in  = '0;
            rem_in   = '0;
            found_in = 1'b0;
         end
         S_BEACON: begin
            strobe_in = 1'b1;
            if (any_hit) begin
               if (hit_ts == wd_ff.sender_time) status_in = ST_DUP;
               else begin
                  status_in = ST_REPLACED;
                  ctrl.write_hit = 1'b1;
               end
            end else if (any_free) begin
               status_in = ST_ADDED;
               ctrl.write_free = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               status_in = ST_FULL;
            end
         end
         S_SCAN: begin
            ctrl.rotate = 1'b1;
            step_in = step_ff + 1'b1;
            if (func_ff == FUNC_CLEAN) begin
               ctrl.evict = 1'b1;
               if (head.valid && head_aged) begin
                  rem_in = rem_ff + 1'b1;
                  cnt_in = cnt_ff - 1'b1;
               end
            end else if (head_fresh) begin
               found_in  = 1'b1;
               strobe_in = 1'b1;
               last_in   = 1'b0;
               status_in = ST_FRESH;
               nid_in    = head.id;
               age_in    = age;
            end
         end
         S_DONE: begin
            strobe_in = func_ff == FUNC_CLEAN || !found_ff;
            status_in = (func_ff == FUNC_CLEAN) ? ST_CLEAN : ST_NONE;
         end
         default: ;
      endcase
   end

   // fresh results are held back until the next one or the done state, so the final one carries last
   logic        pend_ff;
   logic [31:0] pid_ff;
   logic [62:0] page_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cnt_ff     <= '0;
         rsp_strobe <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (status_in == ST_FRESH && strobe_in) begin
            pend_ff <= 1'b1;
            pid_ff  <= nid_in;
            page_ff <= age_in;
         end
         if (pend_ff && (strobe_in || state_ff == S_DONE)) begin
            rsp_strobe <= 1'b1;
            rsp_status <= ST_FRESH;
            rsp_neighbor_id <= pid_ff;
            rsp_age_ns <= page_ff;
            rsp_removed_count <= '0;
            rsp_last <= state_ff == S_DONE;
            if (state_ff == S_DONE) pend_ff <= 1'b0;
         end else if (strobe_in && status_in != ST_FRESH) begin
            rsp_strobe <= 1'b1;
            rsp_status <= status_in;
            rsp_neighbor_id <= '0;
            rsp_age_ns <= '0;
            rsp_removed_count <= (status_in == ST_CLEAN) ? rem_ff : '0;
            rsp_last <= last_in;
         end else begin
            rsp_strobe <= 1'b0;
         end
         rsp_entry_count <= cnt_in;
      end
      step_ff  <= step_in;
      rem_ff   <= rem_in;
      found_ff <= found_in;
   end

   assign busy = state_ff != S_IDLE;

   nlta_chain u_chain (
      .clock(clock), .reset(reset), .ctrl(ctrl), .head(head),
      .any_hit(any_hit), .any_free(any_free), .hit_sender_time(hit_ts)
   );

`ifndef SYNTH
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(TableDepth)) else $error("entry count overflow");
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func != FUNC_SPARE) |=> busy) else $error("item not taken");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> $past(busy)) else $error("result without item");
`endif
endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbour table aging testbench
// drives beacons, clean ticks and fresh queries through several register
// settings; a scoreboard tracks the table and checks every response
// ----------------------------------------------------------------------------
module testbench import nlta_pkg::*; ();

   // tracks table contents and holds the responses each transfer should produce
   class nbr_table_scoreboard;
      typedef struct {
         int          tag;
         logic [2:0]  status;
         logic [31:0] nid;
         logic [62:0] age;
         logic [6:0]  removed;
         logic [6:0]  count;
      } rsp_type;

      logic [31:0] own_id;
      logic [62:0] lifetime;
      logic [62:0] window;
      bit          slot_valid [TableDepth];
      logic [31:0] slot_id    [TableDepth];
      logic [62:0] slot_sent  [TableDepth];
      logic [62:0] slot_arr   [TableDepth];
      int          occupancy;
      rsp_type     pending_rsp [$];
      int          tag_next;
      int          errors;
      int          checked;

      function new();
         own_id = '0;
         lifetime = 63'd1000000000;
         window = 63'd100000000;
         foreach (slot_valid[i]) slot_valid[i] = 0;
         occupancy = 0;
         tag_next = 0;
         errors = 0;
         checked = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [62:0] val);
         case (idx)
            CSR_OWN_ID:   own_id = val[31:0];
            CSR_LIFETIME: lifetime = val;
            CSR_WINDOW:   window = val;
            default: ;
         endcase
      endfunction

      // stored sender time of an id, for provoking duplicates
      function bit stored_time(logic [31:0] id, output logic [62:0] ts);
         ts = '0;
         foreach (slot_valid[i])
            if (slot_valid[i] && slot_id[i] == id) begin
               ts = slot_sent[i];
               return 1;
            end
         return 0;
      endfunction

      function void push(logic [2:0] st, logic [31:0] nid, logic [62:0] age,
                         logic [6:0] removed);
         rsp_type r;
         r.tag = tag_next;
         r.status = st;
         r.nid = nid;
         r.age = age;
         r.removed = removed;
         r.count = occupancy[6:0];
         pending_rsp.insert(pending_rsp.size(), r);
      endfunction

      // predict the responses of one accepted transfer
      function void note_request(logic [1:0] func, logic [31:0] id, logic [62:0] ts,
                                 logic [62:0] now);
         int hit, free, removed, listed;
         logic [62:0] age;
         hit = -1;
         free = -1;
         removed = 0;
         listed = 0;
         tag_next++;
         case (func)
            FUNC_BEACON: begin
               foreach (slot_valid[i])
                  if (slot_valid[i]) begin
                     if (hit < 0 && slot_id[i] == id) hit = i;
                  end else if (free < 0) free = i;
               if (hit >= 0 && slot_sent[hit] == ts)
                  push(ST_DUP, '0, '0, '0);
               else if (hit >= 0) begin
                  slot_sent[hit] = ts;
                  slot_arr[hit] = now;
                  push(ST_REPLACED, '0, '0, '0);
               end else if (free >= 0) begin
                  slot_valid[free] = 1;
                  slot_id[free] = id;
                  slot_sent[free] = ts;
                  slot_arr[free] = now;
                  occupancy++;
                  push(ST_ADDED, '0, '0, '0);
               end else
                  push(ST_FULL, '0, '0, '0);
            end
            FUNC_CLEAN: begin
               foreach (slot_valid[i])
                  if (slot_valid[i] && now >= slot_sent[i] &&
                      now - slot_sent[i] >= lifetime) begin
                     slot_valid[i] = 0;
                     removed++;
                  end
               occupancy -= removed;
               push(ST_CLEAN, '0, '0, removed[6:0]);
            end
            FUNC_FRESH: begin
               foreach (slot_valid[i])
                  if (slot_valid[i] && slot_id[i] != own_id) begin
                     age = (now >= slot_arr[i]) ? now - slot_arr[i] : '0;
                     if (age < window) begin
                        push(ST_FRESH, slot_id[i], age, '0);
                        listed++;
                     end
                  end
               if (listed == 0) push(ST_NONE, '0, '0, '0);
            end
            default: ;
         endcase
      endfunction

      // listing order is free, so a fresh response is matched by id within its query
      function void check_result(logic [2:0] st, logic [31:0] nid, logic [62:0] age,
                                 logic [6:0] removed, logic [6:0] count, logic last);
         rsp_type e;
         logic exp_last;
         checked++;
         if (pending_rsp.size() == 0) begin
            $error("response with nothing expected: status %0d id %h", st, nid);
            errors++;
            return;
         end
         if (pending_rsp[0].status == ST_FRESH && st == ST_FRESH)
            for (int k = 1; k < pending_rsp.size() && pending_rsp[k].tag == pending_rsp[0].tag;
                 k++)
               if (pending_rsp[k].nid == nid) begin
                  e = pending_rsp[k];
                  pending_rsp[k] = pending_rsp[0];
                  pending_rsp[0] = e;
                  break;
               end
         e = pending_rsp.pop_front();
         exp_last = (pending_rsp.size() == 0 || pending_rsp[0].tag != e.tag);
         if (st !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, st); errors++;
         end
         if (nid !== e.nid) begin
            $error("neighbor_id: expected %h, got %h", e.nid, nid); errors++;
         end
         if (age !== e.age) begin
            $error("age_ns: expected %0d, got %0d", e.age, age); errors++;
         end
         if (removed !== e.removed) begin
            $error("removed_count: expected %0d, got %0d", e.removed, removed); errors++;
         end
         if (count !== e.count) begin
            $error("entry_count: expected %0d, got %0d", e.count, count); errors++;
         end
         if (last !== exp_last) begin
            $error("last: expected %0b, got %0b", exp_last, last); errors++;
         end
      endfunction
   endclass

   localparam logic [62:0] TIME_MAX = {63{1'b1}};
   localparam int DRAIN_CYCLES = TableDepth + 8;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_func;
   logic [31:0] req_node_id;
   logic [62:0] req_sender_time_ns;
   logic [31:0] req_latitude;
   logic [31:0] req_longitude;
   logic [15:0] req_speed;
   logic [15:0] req_heading;
   logic [15:0] req_position_index;
   logic [62:0] req_now_ns;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [62:0] csr_wdata;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_neighbor_id;
   logic [62:0] rsp_age_ns;
   logic [6:0]  rsp_removed_count;
   logic [6:0]  rsp_entry_count;
   logic        rsp_last;

   nbr_table_scoreboard table_sb;
   logic [31:0] id_pool [40];
   logic [62:0] clock_ns;
   int          requests_sent;
   int          settings_used;
   bit          no_gaps;

   neighbor_location_table_aging_unit dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // responses sampled mid-cycle, away from the driving edge
   always @(negedge clock)
      if (!reset && rsp_strobe)
         table_sb.check_result(rsp_status, rsp_neighbor_id, rsp_age_ns,
                               rsp_removed_count, rsp_entry_count, rsp_last);

   initial begin
      #2ms;
      $display("timeout waiting for responses");
      $display("Test completed with failures");
      $finish;
   end

   // one command transfer, held until busy is low at a clock edge
   task automatic issue(logic [1:0] func, logic [31:0] id, logic [62:0] ts,
                        logic [31:0] lat, logic [31:0] lon, logic [15:0] spd,
                        logic [15:0] hdg, logic [15:0] pos, logic [62:0] now);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_func <= func;
      req_node_id <= id;
      req_sender_time_ns <= ts;
      req_latitude <= lat;
      req_longitude <= lon;
      req_speed <= spd;
      req_heading <= hdg;
      req_position_index <= pos;
      req_now_ns <= now;
      do @(negedge clock); while (busy);
      table_sb.note_request(func, id, ts, now);
      requests_sent++;
      @(posedge clock);
   endtask

   task automatic beacon(logic [31:0] id, logic [62:0] ts, logic [62:0] now);
      issue(FUNC_BEACON, id, ts, $urandom, $urandom, $urandom, $urandom, $urandom, now);
   endtask

   // wait for all responses, then let the sequencer finish a silent transfer
   task automatic drain();
      start <= 0;
      while (table_sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_regs(logic [31:0] own, logic [62:0] life, logic [62:0] win);
      logic [62:0] vals [3];
      vals = '{{31'd0, own}, life, win};
      for (int i = 0; i < 3; i++) begin
         csr_we <= 1;
         csr_index <= i[1:0];
         csr_wdata <= vals[i];
         table_sb.write_reg(i[1:0], vals[i]);
         @(posedge clock);
      end
      csr_we <= 0;
      settings_used++;
   endtask

   // random traffic around an advancing clock; mostly beacons over a small id pool
   task automatic run_phase(int count, int beacon_pct, int unsigned step);
      int r;
      logic [31:0] id;
      logic [62:0] ts;
      logic [1:0] func;
      for (int n = 0; n < count; n++) begin
         no_gaps = (n % 16) < 5;
         if ($urandom_range(0, 9) == 0 && clock_ns > step) clock_ns -= $urandom_range(0, step);
         else if (clock_ns < TIME_MAX - step) clock_ns += $urandom_range(0, step);
         r = $urandom_range(0, 99);
         func = (r < beacon_pct) ? FUNC_BEACON :
                (r < beacon_pct + (100 - beacon_pct) * 2 / 5) ? FUNC_CLEAN :
                (r < 97) ? FUNC_FRESH : FUNC_SPARE;
         id = id_pool[$urandom_range(0, 39)];
         r = $urandom_range(0, 3);
         if (!(r == 0 && table_sb.stored_time(id, ts))) begin
            if (r == 1 && clock_ns < TIME_MAX - step)
               ts = clock_ns + $urandom_range(1, step);
            else
               ts = (clock_ns > 4 * step) ? clock_ns - $urandom_range(0, 4 * step) : '0;
         end
         issue(func, id, ts, $urandom, $urandom, $urandom, $urandom, $urandom, clock_ns);
      end
      drain();
   endtask

   initial begin
      table_sb = new();
      requests_sent = 0;
      settings_used = 0;
      no_gaps = 0;
      reset = 1;
      start = 0;
      req_func = FUNC_BEACON;
      req_node_id = '0;
      req_sender_time_ns = '0;
      req_latitude = '0;
      req_longitude = '0;
      req_speed = '0;
      req_heading = '0;
      req_position_index = '0;
      req_now_ns = '0;
      csr_we = 0;
      csr_index = CSR_OWN_ID;
      csr_wdata = '0;
      foreach (id_pool[i]) id_pool[i] = $urandom;
      id_pool[0] = '0;
      id_pool[1] = '1;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: default registers, extreme fields and corner cases
      issue(FUNC_FRESH, '0, '0, '0, '0, '0, '0, '0, '0);
      issue(FUNC_BEACON, '0, '0, '0, '0, '0, '0, '0, '0);
      issue(FUNC_BEACON, '1, TIME_MAX, '1, '1, '1, '1, '1, TIME_MAX);
      beacon('0, '0, 63'd500);
      beacon('0, 63'd7, 63'd1000);
      beacon(32'h1234_5678, 63'd2000000000, 63'd50);
      issue(FUNC_SPARE, '1, TIME_MAX, '1, '1, '1, '1, '1, TIME_MAX);
      issue(FUNC_FRESH, '0, '0, '0, '0, '0, '0, '0, 63'd60);
      issue(FUNC_FRESH, '0, '0, '0, '0, '0, '0, '0, 63'd20);
      issue(FUNC_CLEAN, '0, '0, '0, '0, '0, '0, '0, 63'd1000000000);
      issue(FUNC_CLEAN, '0, '0, '0, '0, '0, '0, '0, 63'd1000000007);
      issue(FUNC_FRESH, '0, '0, '0, '0, '0, '0, '0, TIME_MAX);
      issue(FUNC_CLEAN, '0, '0, '0, '0, '0, '0, '0, TIME_MAX);
      drain();

      // zero lifetime and zero window
      set_regs('1, '0, '0);
      beacon('1, 63'd10, 63'd10);
      beacon(32'h0000_00a5, 63'd30, 63'd10);
      issue(FUNC_FRESH, '0, '0, '0, '0, '0, '0, '0, 63'd10);
      issue(FUNC_CLEAN, '0, '0, '0, '0, '0, '0, '0, 63'd10);
      drain();

      // nothing ages, everything fresh
      clock_ns = 63'd1000000;
      set_regs('0, TIME_MAX, TIME_MAX);
      run_phase(50, 85, 1000000);

      // short lifetime and window, own id in the pool
      id_pool[5] = $urandom;
      set_regs(id_pool[5], 63'd3000, 63'd2000);
      run_phase(40, 55, 1000);

      set_regs('1, '0, '0);
      run_phase(15, 60, 100);

      // clock near the top of its range, unit lifetime and window
      clock_ns = TIME_MAX - 63'd5000;
      set_regs($urandom, 63'd1, 63'd1);
      run_phase(20, 60, 10);

      $display("%0d requests over %0d register settings, %0d responses checked",
               requests_sent, settings_used + 1, table_sb.checked);
      if (table_sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
